### rtl/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and helper functions for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEFAULT = 16;

    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;
    localparam logic [7:0] CHAR_ADD   = 8'h2B;
    localparam logic [7:0] CHAR_SUB   = 8'h2D;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [2:0] {
        KIND_SYMBOL    = 3'd0,
        KIND_INVALID   = 3'd1,
        KIND_OVERFLOW  = 3'd2,
        KIND_UNMATCHED = 3'd3,
        KIND_END       = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_OP_READ,
        ST_OP_EVAL,
        ST_PUSH,
        ST_CL_READ,
        ST_CL_EVAL,
        ST_FL_READ,
        ST_FL_EVAL,
        ST_FINISH
    } state_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c == CHAR_MUL || c == CHAR_DIV || c == CHAR_ADD || c == CHAR_SUB;
    endfunction

    function automatic logic is_high_prec(input logic [7:0] c);
        return c == CHAR_MUL || c == CHAR_DIV;
    endfunction

endpackage
`default_nettype wire

### rtl/infix_to_postfix_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard conversion of an infix character stream to postfix order.
// ----------------------------------------------------------------------------
// One character is taken per input transfer and handled by a small sequencer
// around an operator stack held in a memory with a registered read port.
// A letter or an invalid character is emitted at once and a '(' is pushed.
// An operator pops and emits every stacked operator of equal or higher
// precedence, stops at the first other entry, and is then pushed. A ')' pops
// and emits entries until its '(' is removed, and reports an unmatched ')'
// when no '(' is found. The end of an expression emits every operator
// still on the stack, drops any '(' left there and ends with an end marker;
// stalls on the result channel hold the sequencer. Every result passes
// through a one-entry hold stage so that the last result of a character can
// be marked, and then through the output register. The block is not ready
// for a new character until all results of the previous one are queued.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_end_of_expr,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic [2:0]      m_kind,
    output logic            m_last_of_run
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0] op_stack [STACK_DEPTH];

    itp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      char_reg, char_next;
    logic            eod_reg, eod_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [7:0]      hold_char_reg, hold_char_next;
    itp_pkg::kind_t  hold_kind_reg, hold_kind_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    itp_pkg::kind_t  out_kind_reg, out_kind_next;
    logic            out_last_reg, out_last_next;
    logic [7:0]      rd_data_reg;

    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   top_idx;
    logic [AW-1:0]   push_idx;
    logic            count_zero;
    logic            count_full;
    logic            rd_en;
    logic            wr_en;
    logic            out_free;
    logic            can_emit;
    logic            emit_req;
    logic [7:0]      emit_char;
    itp_pkg::kind_t  emit_kind;
    itp_pkg::state_t after_state;

    assign count_m1    = count_reg - CW'(1);
    assign top_idx     = count_m1[AW-1:0];
    assign push_idx    = count_reg[AW-1:0];
    assign count_zero  = (count_reg == '0);
    assign count_full  = (count_reg >= CW'(STACK_DEPTH));
    assign out_free    = !out_valid_reg || m_ready;
    assign can_emit    = !hold_valid_reg || out_free;
    assign after_state = eod_reg ? itp_pkg::ST_FL_READ : itp_pkg::ST_FINISH;

    assign s_ready       = (state_reg == itp_pkg::ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_kind        = out_kind_reg;
    assign m_last_of_run = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= itp_pkg::ST_IDLE;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        eod_reg       <= eod_next;
        hold_char_reg <= hold_char_next;
        hold_kind_reg <= hold_kind_next;
        out_char_reg  <= out_char_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            op_stack[push_idx] <= char_reg;
        end
        if (rd_en) begin
            rd_data_reg <= op_stack[top_idx];
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        char_next       = char_reg;
        eod_next        = eod_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        hold_kind_next  = hold_kind_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_char_next   = out_char_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        emit_req        = 1'b0;
        emit_char       = char_reg;
        emit_kind       = itp_pkg::KIND_SYMBOL;

        case (state_reg)
            itp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    char_next  = s_in_char;
                    eod_next   = s_end_of_expr;
                    state_next = itp_pkg::ST_DISPATCH;
                end
            end
            itp_pkg::ST_DISPATCH: begin
                if (itp_pkg::is_letter(char_reg)) begin
                    emit_req = 1'b1;
                    if (can_emit) begin
                        state_next = after_state;
                    end
                end else if (char_reg == itp_pkg::CHAR_OPEN) begin
                    state_next = itp_pkg::ST_PUSH;
                end else if (itp_pkg::is_operator(char_reg)) begin
                    state_next = itp_pkg::ST_OP_READ;
                end else if (char_reg == itp_pkg::CHAR_CLOSE) begin
                    state_next = itp_pkg::ST_CL_READ;
                end else begin
                    emit_req  = 1'b1;
                    emit_kind = itp_pkg::KIND_INVALID;
                    if (can_emit) begin
                        state_next = after_state;
                    end
                end
            end
            itp_pkg::ST_OP_READ: begin
                if (count_zero) begin
                    state_next = itp_pkg::ST_PUSH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = itp_pkg::ST_OP_EVAL;
                end
            end
            itp_pkg::ST_OP_EVAL: begin
                if (itp_pkg::is_operator(rd_data_reg) &&
                    (itp_pkg::is_high_prec(rd_data_reg) ||
                     !itp_pkg::is_high_prec(char_reg))) begin
                    emit_req  = 1'b1;
                    emit_char = rd_data_reg;
                    if (can_emit) begin
                        count_next = count_m1;
                        state_next = itp_pkg::ST_OP_READ;
                    end
                end else begin
                    state_next = itp_pkg::ST_PUSH;
                end
            end
            itp_pkg::ST_PUSH: begin
                if (count_full) begin
                    emit_req  = 1'b1;
                    emit_kind = itp_pkg::KIND_OVERFLOW;
                    if (can_emit) begin
                        state_next = after_state;
                    end
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = after_state;
                end
            end
            itp_pkg::ST_CL_READ: begin
                if (count_zero) begin
                    emit_req  = 1'b1;
                    emit_kind = itp_pkg::KIND_UNMATCHED;
                    if (can_emit) begin
                        state_next = after_state;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = itp_pkg::ST_CL_EVAL;
                end
            end
            itp_pkg::ST_CL_EVAL: begin
                if (rd_data_reg == itp_pkg::CHAR_OPEN) begin
                    count_next = count_m1;
                    state_next = after_state;
                end else begin
                    emit_req  = 1'b1;
                    emit_char = rd_data_reg;
                    if (can_emit) begin
                        count_next = count_m1;
                        state_next = itp_pkg::ST_CL_READ;
                    end
                end
            end
            itp_pkg::ST_FL_READ: begin
                if (count_zero) begin
                    emit_req  = 1'b1;
                    emit_char = itp_pkg::CHAR_NUL;
                    emit_kind = itp_pkg::KIND_END;
                    if (can_emit) begin
                        state_next = itp_pkg::ST_FINISH;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = itp_pkg::ST_FL_EVAL;
                end
            end
            itp_pkg::ST_FL_EVAL: begin
                if (rd_data_reg == itp_pkg::CHAR_OPEN) begin
                    count_next = count_m1;
                    state_next = itp_pkg::ST_FL_READ;
                end else begin
                    emit_req  = 1'b1;
                    emit_char = rd_data_reg;
                    if (can_emit) begin
                        count_next = count_m1;
                        state_next = itp_pkg::ST_FL_READ;
                    end
                end
            end
            itp_pkg::ST_FINISH: begin
                if (!hold_valid_reg) begin
                    state_next = itp_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = hold_char_reg;
                    out_kind_next   = hold_kind_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = itp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itp_pkg::ST_IDLE;
            end
        endcase

        // A new result displaces the held one, which is then known not to be
        // the last result of its character.
        if (emit_req && can_emit) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_char_next  = hold_char_reg;
                out_kind_next  = hold_kind_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_char_next  = emit_char;
            hold_kind_next  = emit_kind;
        end
    end

endmodule
`default_nettype wire
